// ===== sv/wspc_pkg.sv =====
// Shared constants, codes and control types for the wheel speed PID controller.
`timescale 1ns / 1ps
package wspc_pkg;

    // Block sizing
    localparam int EDGE_HISTORY    = 4;
    localparam int DIV_STEPS       = 64;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

    // Divide by one million: six 12-bit digits, each formed and then taken from the remainder
    localparam logic [3:0]  CDIV_CYCLES     = 4'd12;
    localparam logic [32:0] USEC_RECIP      = 33'd4503599628;

    // Arithmetic constants
    localparam logic [6:0]  STALL_OVERFLOWS = 7'd64;
    localparam logic [6:0]  OVF_SAT         = 7'd127;
    localparam logic [63:0] SPEED_K         = 64'd9193454617;
    localparam logic [31:0] USEC_PER_SEC    = 32'd1000000;
    localparam logic [30:0] SPEED_MAX       = 31'h7FFF_FFFF;
    localparam logic [14:0] DERIV_MAX       = 15'h7FFF;
    localparam logic [7:0]  PWM_MAX         = 8'd255;

    // Input operation codes
    localparam logic [1:0] OP_EDGE   = 2'd0;
    localparam logic [1:0] OP_OVF    = 2'd1;
    localparam logic [1:0] OP_CTRL   = 2'd2;
    localparam logic [1:0] OP_TRESET = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_KP    = 3'd0;
    localparam logic [2:0] CFG_KI    = 3'd1;
    localparam logic [2:0] CFG_KD    = 3'd2;
    localparam logic [2:0] CFG_LIMIT = 3'd3;
    localparam logic [2:0] CFG_POL   = 3'd4;

    // Multiplier operand selects
    localparam logic [2:0] MS_INC = 3'd0;
    localparam logic [2:0] MS_DER = 3'd1;
    localparam logic [2:0] MS_P   = 3'd2;
    localparam logic [2:0] MS_I   = 3'd3;
    localparam logic [2:0] MS_D   = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic       accept;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       diff;
        logic       div_start;
        logic [1:0] div_sel;
        logic       upd_speed;
        logic       upd_integ;
        logic       upd_deriv;
        logic       acc_load;
        logic       acc_add;
        logic       acc_add_sh;
        logic       p51;
        logic       pwm;
        logic       load_out;
    } t_cmd;

    // Divider operand selects
    localparam logic [1:0] DS_SPEED = 2'd0;
    localparam logic [1:0] DS_INC   = 2'd1;
    localparam logic [1:0] DS_DER   = 2'd2;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

// ===== sv/wspc_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
module wspc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic [wspc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [32:0]                    r_rem;
    logic [63:0]                    r_quo;
    logic [31:0]                    r_dsr;
    logic [32:0]                    rem_sh;
    logic                           q_bit;

    // Shift in the next dividend bit and try the subtract
    assign rem_sh = {r_rem[31:0], r_quo[63]};
    assign q_bit  = (rem_sh >= {1'b0, r_dsr});

    // Sequence the steps; done pulses for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= wspc_pkg::DIV_CNT_W'(wspc_pkg::DIV_STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == wspc_pkg::DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Hold remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= q_bit ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
            r_quo <= {r_quo[62:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/wspc_dp.sv =====
// Datapath: configuration, encoder state, PID arithmetic and result word registers.
`timescale 1ns / 1ps
module wspc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wspc_pkg::t_cmd       i_cmd,
    output wspc_pkg::t_sts       o_sts,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_time_us,
    input  logic                 i_encoder_dir_pin,
    input  logic signed [31:0]   i_target_speed,
    output logic                 o_drive_dir,
    output logic [7:0]           o_drive_duty,
    output logic signed [31:0]   o_measured_speed,
    output logic signed [31:0]   o_tick_count
);

    // Configuration
    logic signed [31:0] r_kp, r_ki, r_kd;
    logic [30:0]        r_limit;
    logic               r_pol;

    // Persistent state
    logic [31:0]        r_edge [wspc_pkg::EDGE_HISTORY];
    logic signed [31:0] r_speed;
    logic [31:0]        r_ticks;
    logic [6:0]         r_ovf;
    logic [31:0]        r_last;
    logic signed [31:0] r_integ;
    logic signed [31:0] r_prev;
    logic               r_dir;
    logic [7:0]         r_duty;

    // Working registers
    logic [31:0]        r_span;
    logic               r_rev;
    logic [31:0]        r_dt;
    logic signed [31:0] r_err;
    logic signed [32:0] r_diff;
    logic signed [15:0] r_deriv;
    logic signed [67:0] r_prod;
    logic signed [67:0] r_acc;
    logic signed [72:0] r_p51;

    // Division by one million
    logic [71:0]        r_cd_num;
    logic [19:0]        r_cd_rem;
    logic [11:0]        r_cd_dig;
    logic [44:0]        r_cd_quo;
    logic [3:0]         r_cd_cnt;
    logic               r_cd_done;
    logic               cd_start;
    logic [31:0]        cd_y;
    logic [64:0]        cd_prod;
    logic [31:0]        cd_sub;

    logic               div_start;
    logic               div_done;
    logic [63:0]        div_q;
    logic [63:0]        div_n;
    logic [31:0]        div_d;

    logic signed [32:0] err_wide;
    logic signed [31:0] err_sat;
    logic [6:0]         ovf_next;
    logic [32:0]        err_mag;
    logic [33:0]        diff_neg;
    logic [32:0]        diff_mag;
    logic signed [33:0] mul_a, mul_b;
    logic [30:0]        spd_mag;
    logic signed [46:0] integ_sum, lim_pos;
    logic [14:0]        der_mag;
    logic signed [72:0] acc_ext;
    logic [72:0]        p_mag;
    logic [7:0]         pwm_mag;
    logic               pwm_nonneg;

    // Saturated error against the current speed estimate
    assign err_wide = 33'(i_target_speed) - 33'(r_speed);
    assign err_sat  = (err_wide[32] != err_wide[31])
                      ? (err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                      : err_wide[31:0];
    assign ovf_next = (r_ovf != wspc_pkg::OVF_SAT) ? r_ovf + 7'd1 : r_ovf;

    // Operand magnitudes
    assign err_mag  = r_err[31] ? -(33'(r_err)) : 33'(r_err);
    assign diff_neg = -(34'(r_diff));
    assign diff_mag = r_diff[32] ? diff_neg[32:0] : r_diff;

    // Multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            wspc_pkg::MS_INC: begin
                mul_a = {1'b0, err_mag};
                mul_b = {2'b00, r_dt};
            end
            wspc_pkg::MS_DER: begin
                mul_a = {1'b0, diff_mag};
                mul_b = {2'b00, wspc_pkg::USEC_PER_SEC};
            end
            wspc_pkg::MS_P: begin
                mul_a = 34'(r_kp);
                mul_b = 34'(r_err);
            end
            wspc_pkg::MS_I: begin
                mul_a = 34'(r_ki);
                mul_b = 34'(r_integ);
            end
            wspc_pkg::MS_D: begin
                mul_a = 34'(r_kd);
                mul_b = 34'(r_deriv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Route the start: the integral increment goes to the divide-by-million unit
    assign cd_start  = i_cmd.div_start && (i_cmd.div_sel == wspc_pkg::DS_INC);
    assign div_start = i_cmd.div_start && (i_cmd.div_sel != wspc_pkg::DS_INC);

    // Divider operand select
    always_comb begin
        unique case (i_cmd.div_sel)
            wspc_pkg::DS_SPEED: begin
                div_n = wspc_pkg::SPEED_K;
                div_d = r_span;
            end
            wspc_pkg::DS_DER: begin
                div_n = {16'd0, r_prod[63:16]};
                div_d = r_dt;
            end
            default: begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    wspc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_sts.div_done = div_done | r_cd_done;

    // Long division by one million, 12-bit digits: the remainder stays below
    // one million, so each partial dividend fits 32 bits and the reciprocal
    // product gives the exact digit
    assign cd_y    = {r_cd_rem, r_cd_num[71:60]};
    assign cd_prod = 65'(cd_y) * 65'(wspc_pkg::USEC_RECIP);
    assign cd_sub  = cd_y - ({20'd0, r_cd_dig} * wspc_pkg::USEC_PER_SEC);

    // Sequence the digits: even counts form the digit, odd counts take the remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_cnt  <= '0;
            r_cd_done <= 1'b0;
        end else if (cd_start) begin
            r_cd_cnt  <= wspc_pkg::CDIV_CYCLES;
            r_cd_done <= 1'b0;
        end else if (r_cd_cnt != '0) begin
            r_cd_cnt  <= r_cd_cnt - 4'd1;
            r_cd_done <= (r_cd_cnt == 4'd1);
        end else begin
            r_cd_done <= 1'b0;
        end
    end

    // Hold dividend, remainder and quotient digits
    always_ff @(posedge i_clk) begin
        if (cd_start) begin
            r_cd_num <= {8'd0, r_prod[63:0]};
            r_cd_rem <= '0;
        end else if (r_cd_cnt != '0) begin
            if (!r_cd_cnt[0]) begin
                r_cd_dig <= cd_prod[63:52];
            end else begin
                r_cd_rem <= cd_sub[19:0];
                r_cd_quo <= {r_cd_quo[32:0], r_cd_dig};
                r_cd_num <= {r_cd_num[59:0], 12'd0};
            end
        end
    end

    // Saturate quotients
    assign spd_mag   = (|div_q[63:31]) ? wspc_pkg::SPEED_MAX : div_q[30:0];
    assign der_mag   = (|div_q[63:15]) ? wspc_pkg::DERIV_MAX : div_q[14:0];
    assign integ_sum = r_err[31] ? 47'(r_integ) - 47'({2'b00, r_cd_quo})
                                 : 47'(r_integ) + 47'({2'b00, r_cd_quo});
    assign lim_pos   = 47'({16'd0, r_limit});

    // Output law: trunc toward zero of 51*v, clamped
    assign acc_ext    = 73'(r_acc);
    assign p_mag      = r_p51[72] ? -r_p51 : r_p51;
    assign pwm_mag    = (|p_mag[72:40]) ? wspc_pkg::PWM_MAX : p_mag[39:32];
    assign pwm_nonneg = !r_p51[72] || (pwm_mag == 8'd0);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_limit <= '0;
            r_pol   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wspc_pkg::CFG_KP:    r_kp    <= i_cfg_data;
                wspc_pkg::CFG_KI:    r_ki    <= i_cfg_data;
                wspc_pkg::CFG_KD:    r_kd    <= i_cfg_data;
                wspc_pkg::CFG_LIMIT: r_limit <= i_cfg_data[30:0];
                wspc_pkg::CFG_POL:   r_pol   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Encoder and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wspc_pkg::EDGE_HISTORY; i++) r_edge[i] <= '0;
            r_speed <= '0;
            r_ticks <= '0;
            r_ovf   <= '0;
            r_last  <= '0;
            r_integ <= '0;
            r_prev  <= '0;
            r_dir   <= 1'b0;
            r_duty  <= '0;
        end else begin
            if (i_cmd.accept) begin
                unique case (i_op)
                    wspc_pkg::OP_EDGE: begin
                        for (int i = wspc_pkg::EDGE_HISTORY - 1; i > 0; i--)
                            r_edge[i] <= r_edge[i-1];
                        r_edge[0] <= i_time_us;
                        r_ticks   <= i_encoder_dir_pin ? r_ticks - 32'd1 : r_ticks + 32'd1;
                        r_ovf     <= '0;
                    end
                    wspc_pkg::OP_OVF: begin
                        r_ovf <= ovf_next;
                        if (ovf_next > wspc_pkg::STALL_OVERFLOWS) r_speed <= '0;
                    end
                    wspc_pkg::OP_CTRL:   r_last  <= i_time_us;
                    wspc_pkg::OP_TRESET: r_ticks <= '0;
                    default: ;
                endcase
            end
            // Install the new speed estimate
            if (i_cmd.upd_speed)
                r_speed <= r_rev ? -(32'({1'b0, spd_mag})) : 32'({1'b0, spd_mag});
            // Accumulate and clamp the integral
            if (i_cmd.upd_integ) begin
                priority if (integ_sum > lim_pos)  r_integ <= {1'b0, r_limit};
                else if (integ_sum < -lim_pos)     r_integ <= -(32'({1'b0, r_limit}));
                else                               r_integ <= integ_sum[31:0];
            end
            if (i_cmd.diff) r_prev <= r_err;
            // Map the duty to the bridge
            if (i_cmd.pwm) begin
                if (r_pol) begin
                    r_dir  <= !pwm_nonneg;
                    r_duty <= pwm_nonneg ? pwm_mag : wspc_pkg::PWM_MAX - pwm_mag;
                end else begin
                    r_dir  <= pwm_nonneg;
                    r_duty <= pwm_nonneg ? wspc_pkg::PWM_MAX - pwm_mag : pwm_mag;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_span <= i_time_us - r_edge[wspc_pkg::EDGE_HISTORY-1];
            r_rev  <= i_encoder_dir_pin;
            r_dt   <= i_time_us - r_last;
            r_err  <= err_sat;
        end
        if (i_cmd.diff)   r_diff <= 33'(r_err) - 33'(r_prev);
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
        if (i_cmd.upd_deriv) begin
            if (r_dt == '0)      r_deriv <= '0;
            else if (r_diff[32]) r_deriv <= -(16'({1'b0, der_mag}));
            else                 r_deriv <= 16'({1'b0, der_mag});
        end
        if (i_cmd.acc_load)   r_acc <= r_prod;
        if (i_cmd.acc_add)    r_acc <= r_acc + r_prod;
        if (i_cmd.acc_add_sh) r_acc <= r_acc + (r_prod <<< 16);
        if (i_cmd.p51)
            r_p51 <= (acc_ext <<< 5) + (acc_ext <<< 4) + (acc_ext <<< 1) + acc_ext;
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_drive_dir      <= r_dir;
            o_drive_duty     <= r_duty;
            o_measured_speed <= r_speed;
            o_tick_count     <= r_ticks;
        end
    end

endmodule

// ===== sv/wspc_ctrl.sv =====
// Controller: sequences each word through the datapath and drives both handshakes.
`timescale 1ns / 1ps
module wspc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_op,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output wspc_pkg::t_cmd o_cmd,
    input  wspc_pkg::t_sts i_sts
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_E_DIV  = 4'd1;
    localparam logic [3:0] ST_E_WAIT = 4'd2;
    localparam logic [3:0] ST_C_MULI = 4'd3;
    localparam logic [3:0] ST_C_DIVI = 4'd4;
    localparam logic [3:0] ST_C_WTI  = 4'd5;
    localparam logic [3:0] ST_C_MULD = 4'd6;
    localparam logic [3:0] ST_C_DIVD = 4'd7;
    localparam logic [3:0] ST_C_WTD  = 4'd8;
    localparam logic [3:0] ST_C_MP   = 4'd9;
    localparam logic [3:0] ST_C_MI   = 4'd10;
    localparam logic [3:0] ST_C_MD   = 4'd11;
    localparam logic [3:0] ST_C_AD   = 4'd12;
    localparam logic [3:0] ST_C_P51  = 4'd13;
    localparam logic [3:0] ST_C_PWM  = 4'd14;
    localparam logic [3:0] ST_DONE   = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       take;

    assign take       = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.accept = take;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_op == wspc_pkg::OP_EDGE) n_state = ST_E_DIV;
                    else if (i_op == wspc_pkg::OP_CTRL)     n_state = ST_C_MULI;
                    else                                    n_state = ST_DONE;
                end
            end
            ST_E_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wspc_pkg::DS_SPEED;
                n_state         = ST_E_WAIT;
            end
            ST_E_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.upd_speed = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_C_MULI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = wspc_pkg::MS_INC;
                o_cmd.diff    = 1'b1;
                n_state       = ST_C_DIVI;
            end
            ST_C_DIVI: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wspc_pkg::DS_INC;
                n_state         = ST_C_WTI;
            end
            ST_C_WTI: begin
                if (i_sts.div_done) begin
                    o_cmd.upd_integ = 1'b1;
                    n_state         = ST_C_MULD;
                end
            end
            ST_C_MULD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = wspc_pkg::MS_DER;
                n_state       = ST_C_DIVD;
            end
            ST_C_DIVD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = wspc_pkg::DS_DER;
                n_state         = ST_C_WTD;
            end
            ST_C_WTD: begin
                if (i_sts.div_done) begin
                    o_cmd.upd_deriv = 1'b1;
                    n_state         = ST_C_MP;
                end
            end
            ST_C_MP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = wspc_pkg::MS_P;
                n_state       = ST_C_MI;
            end
            ST_C_MI: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = wspc_pkg::MS_I;
                o_cmd.acc_load = 1'b1;
                n_state        = ST_C_MD;
            end
            ST_C_MD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = wspc_pkg::MS_D;
                o_cmd.acc_add = 1'b1;
                n_state       = ST_C_AD;
            end
            ST_C_AD: begin
                o_cmd.acc_add_sh = 1'b1;
                n_state          = ST_C_P51;
            end
            ST_C_P51: begin
                o_cmd.p51 = 1'b1;
                n_state   = ST_C_PWM;
            end
            ST_C_PWM: begin
                o_cmd.pwm = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_comb begin
        priority if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (!i_out_stall)       n_out_valid = 1'b0;
        else                         n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_ctrl_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_op == wspc_pkg::OP_CTRL)
        |=> (r_state == ST_C_MULI))
        else $error("control word did not start the PID sequence");

    a_edge_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_E_WAIT && i_sts.div_done) |=> (r_state == ST_DONE))
        else $error("edge word did not finish after division");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && i_out_stall)
        |=> (r_state == ST_DONE && r_out_valid))
        else $error("result overwrote a stalled output word");

    a_no_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !(r_out_valid && i_out_stall))
        |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished word not loaded to output");
`endif

endmodule

// ===== sv/wheel_speed_pid_controller.sv =====
// Top level of the wheel speed PID controller: controller plus datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_op, i_time_us, i_encoder_dir_pin,
//          |           |                         | i_target_speed
//  out     | output    | o_out_valid/i_out_stall | o_drive_dir, o_drive_duty,
//          |           |                         | o_measured_speed, o_tick_count
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Overflow and tick reset words go straight to the output register; an encoder edge
// makes one pass through the 64-step restoring divider, and a control step makes one
// pass and also divides by one million a digit at a time. Every result word is
// registered in the output register before it is shown.
// Synchronous active-low reset clears persistent state, configuration and the output valid.
// A stalled output word holds; the block takes the next input word while it waits.
`timescale 1ns / 1ps
module wheel_speed_pid_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_time_us,
    input  logic               i_encoder_dir_pin,
    input  logic signed [31:0] i_target_speed,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_drive_dir,
    output logic [7:0]         o_drive_duty,
    output logic signed [31:0] o_measured_speed,
    output logic signed [31:0] o_tick_count
);

    wspc_pkg::t_cmd cmd;
    wspc_pkg::t_sts sts;

    wspc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    wspc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_time_us         (i_time_us),
        .i_encoder_dir_pin (i_encoder_dir_pin),
        .i_target_speed    (i_target_speed),
        .o_drive_dir       (o_drive_dir),
        .o_drive_duty      (o_drive_duty),
        .o_measured_speed  (o_measured_speed),
        .o_tick_count      (o_tick_count)
    );

endmodule
